// ===== rtl/core/height_profile_checker_assert.svh =====
// Assertion macros used by the height profile checker verification file hpc_checker.sv.
`ifndef HEIGHT_PROFILE_CHECKER_ASSERT_SVH
`define HEIGHT_PROFILE_CHECKER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define HPC_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("height_profile_checker assertion failed");

// The condition must hold in the cycle after the trigger.
`define HPC_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("height_profile_checker assertion failed");

// The condition must hold later than the trigger (non-overlapped implication with an added delay).
`define HPC_ASSERT_LATER(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> ##1 (cond)) \
    else $error("height_profile_checker assertion failed");

`endif

// ===== rtl/core/hpc_pkg.sv =====
// Types and constants of the height profile checker.
`timescale 1ns / 1ps
package hpc_pkg;

  localparam int HeightW = 12;
  localparam int TolW    = 8;
  localparam int CmpW    = 14;
  localparam int IdxW    = 3;
  localparam int CfgW    = 12;
  localparam int InDataW  = 16;
  localparam int OutDataW = 8;

  localparam logic [IdxW-1:0] REG_TOLERANCE  = 3'd0;
  localparam logic [IdxW-1:0] REG_BELT_LEVEL = 3'd1;
  localparam logic [IdxW-1:0] REG_WIN_A_HIGH = 3'd2;
  localparam logic [IdxW-1:0] REG_WIN_A_LOW  = 3'd3;
  localparam logic [IdxW-1:0] REG_WIN_B_HIGH = 3'd4;
  localparam logic [IdxW-1:0] REG_WIN_B_LOW  = 3'd5;
  localparam logic [IdxW-1:0] REG_WIN_C_HIGH = 3'd6;
  localparam logic [IdxW-1:0] REG_WIN_C_LOW  = 3'd7;

  localparam logic [TolW-1:0]    RST_TOLERANCE  = 8'd20;
  localparam logic [HeightW-1:0] RST_BELT_LEVEL = 12'd3769;
  localparam logic [HeightW-1:0] RST_WIN_A_HIGH = 12'd3457;
  localparam logic [HeightW-1:0] RST_WIN_A_LOW  = 12'd3358;
  localparam logic [HeightW-1:0] RST_WIN_B_HIGH = 12'd3727;
  localparam logic [HeightW-1:0] RST_WIN_B_LOW  = 12'd3689;
  localparam logic [HeightW-1:0] RST_WIN_C_HIGH = 12'd3112;
  localparam logic [HeightW-1:0] RST_WIN_C_LOW  = 12'd3033;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_A1     = 3'd1,
    PH_B      = 3'd2,
    PH_A2     = 3'd3,
    PH_C      = 3'd4,
    PH_ACCEPT = 3'd5,
    PH_REJECT = 3'd6
  } phase_t;

  typedef struct packed {
    logic [TolW-1:0]    tolerance;
    logic [HeightW-1:0] belt_level;
    logic [HeightW-1:0] win_a_high;
    logic [HeightW-1:0] win_a_low;
    logic [HeightW-1:0] win_b_high;
    logic [HeightW-1:0] win_b_low;
    logic [HeightW-1:0] win_c_high;
    logic [HeightW-1:0] win_c_low;
  } cfg_t;

  typedef struct packed {
    logic win_a;
    logic win_b;
    logic win_c;
    logic belt;
  } hits_t;

endpackage

// ===== rtl/core/hpc_classify.sv =====
// Window and belt-level compares of one height sample.
`timescale 1ns / 1ps
module hpc_classify (
  input  hpc_pkg::cfg_t                    cfg,
  input  logic [hpc_pkg::HeightW-1:0]      height_sample,
  output hpc_pkg::hits_t                   hits
);
  import hpc_pkg::*;

  logic signed [CmpW-1:0] h;
  logic signed [CmpW-1:0] t;

  function automatic logic signed [CmpW-1:0] ext(input logic [HeightW-1:0] v);
    ext = $signed({{(CmpW-HeightW){1'b0}}, v});
  endfunction

  function automatic logic in_win(input logic signed [CmpW-1:0] s,
                                  input logic signed [CmpW-1:0] tol,
                                  input logic [HeightW-1:0] lo,
                                  input logic [HeightW-1:0] hi);
    in_win = (s <= ext(hi) + tol) && (s >= ext(lo) - tol);
  endfunction

  assign h = ext(height_sample);
  assign t = $signed({{(CmpW-TolW){1'b0}}, cfg.tolerance});

  assign hits.win_a = in_win(h, t, cfg.win_a_low, cfg.win_a_high);
  assign hits.win_b = in_win(h, t, cfg.win_b_low, cfg.win_b_high);
  assign hits.win_c = in_win(h, t, cfg.win_c_low, cfg.win_c_high);
  assign hits.belt  = h >= ext(cfg.belt_level) - t;

endmodule

// ===== rtl/core/height_profile_checker.sv =====
// Top level of the height profile checker.
// Usage: height samples enter on the s_ stream, one item per sample. s_tdata carries
// the 12-bit height in its low bits; s_tuser carries the position flags.
// Each accepted item yields exactly one result item on the m_ stream: the new phase
// code in m_tdata and the part-ok flag in m_tuser.
// Pipeline: there is one input register and one result register, with the window
// compares and phase update between them; m_tvalid rises when the result register
// is loaded.
// Throughput is one item per cycle while m_tready stays high; the phase register is
// the only loop and is updated from the combinational phase logic.
// When the receiver holds m_tready low, the result stays put and one more item can
// wait in the input register; s_tready then drops until the result is taken.
// Reset clears both stages, returns the phase to idle and loads the default window,
// belt and tolerance values. Configuration writes take effect at the next edge and
// should only be issued while no item is in flight.
`timescale 1ns / 1ps
module height_profile_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [hpc_pkg::IdxW-1:0]      cfg_index,
  input  logic [hpc_pkg::CfgW-1:0]      cfg_wr_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [hpc_pkg::InDataW-1:0]   s_tdata,   // [11:0] height_sample, [15:12] zero
  input  logic [1:0]                    s_tuser,   // [0] at_metal_detector, [1] at_belt_start
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [hpc_pkg::OutDataW-1:0]  m_tdata,   // [2:0] phase_code, [7:3] zero
  output logic                          m_tuser    // [0] part_ok
);
  import hpc_pkg::*;

  cfg_t                cfg;
  logic                in_valid;
  logic [HeightW-1:0]  in_height;
  logic                in_metal;
  logic                in_start;
  hits_t               hits;
  phase_t              phase;
  phase_t              phase_next;
  logic                part_ok_next;
  logic                advance;
  logic                out_valid;
  phase_t              out_phase;
  logic                out_part_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance  <= RST_TOLERANCE;
      cfg.belt_level <= RST_BELT_LEVEL;
      cfg.win_a_high <= RST_WIN_A_HIGH;
      cfg.win_a_low  <= RST_WIN_A_LOW;
      cfg.win_b_high <= RST_WIN_B_HIGH;
      cfg.win_b_low  <= RST_WIN_B_LOW;
      cfg.win_c_high <= RST_WIN_C_HIGH;
      cfg.win_c_low  <= RST_WIN_C_LOW;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TOLERANCE:  cfg.tolerance  <= cfg_wr_data[TolW-1:0];
        REG_BELT_LEVEL: cfg.belt_level <= cfg_wr_data[HeightW-1:0];
        REG_WIN_A_HIGH: cfg.win_a_high <= cfg_wr_data[HeightW-1:0];
        REG_WIN_A_LOW:  cfg.win_a_low  <= cfg_wr_data[HeightW-1:0];
        REG_WIN_B_HIGH: cfg.win_b_high <= cfg_wr_data[HeightW-1:0];
        REG_WIN_B_LOW:  cfg.win_b_low  <= cfg_wr_data[HeightW-1:0];
        REG_WIN_C_HIGH: cfg.win_c_high <= cfg_wr_data[HeightW-1:0];
        REG_WIN_C_LOW:  cfg.win_c_low  <= cfg_wr_data[HeightW-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_height <= s_tdata[HeightW-1:0];
      in_metal  <= s_tuser[0];
      in_start  <= s_tuser[1];
    end
  end

  hpc_classify u_classify (
    .cfg           (cfg),
    .height_sample (in_height),
    .hits          (hits)
  );

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_A1:     phase_next = hits.win_a ? PH_A1 : (hits.win_b ? PH_B : PH_REJECT);
      PH_B:      phase_next = hits.win_b ? PH_B : (hits.win_a ? PH_A2 : PH_REJECT);
      PH_A2:     phase_next = hits.win_a ? PH_A2 : (hits.win_c ? PH_C : PH_REJECT);
      PH_C:      phase_next = hits.win_c ? PH_C : (hits.belt ? PH_ACCEPT : PH_REJECT);
      PH_ACCEPT: phase_next = (hits.belt && in_metal) ? PH_IDLE : PH_ACCEPT;
      PH_REJECT: phase_next = in_start ? PH_IDLE : PH_REJECT;
      default:   phase_next = hits.belt ? PH_IDLE : (hits.win_a ? PH_A1 : PH_REJECT);
    endcase
  end

  always_comb begin
    part_ok_next = (phase_next != PH_REJECT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_phase   <= phase_next;
      out_part_ok <= part_ok_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutDataW-3){1'b0}}, out_phase};
  assign m_tuser  = out_part_ok;

endmodule

// ===== rtl/core/hpc_checker.sv =====
// Port-level assertions of the height profile checker and their binding.
`timescale 1ns / 1ps
`include "height_profile_checker_assert.svh"
module hpc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_wr_en,
  input logic [hpc_pkg::IdxW-1:0]      cfg_index,
  input logic [hpc_pkg::CfgW-1:0]      cfg_wr_data,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [hpc_pkg::InDataW-1:0]   s_tdata,
  input logic [1:0]                    s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [hpc_pkg::OutDataW-1:0]  m_tdata,
  input logic                          m_tuser
);
  import hpc_pkg::*;

  logic unused_ok;

  assign unused_ok = cfg_wr_en ^ (|cfg_index) ^ (|cfg_wr_data) ^ (|s_tdata) ^ (|s_tuser);

  // The part-ok flag is low exactly when the reported phase is the rejected one.
  `HPC_ASSERT_NOW(a_part_ok_matches, m_tvalid, m_tuser == (m_tdata[2:0] != PH_REJECT))

  // The unused result bits are always zero.
  `HPC_ASSERT_NOW(a_out_pad_zero, m_tvalid, m_tdata[OutDataW-1:3] == '0)

  // Every accepted item has a result waiting once it has passed the input and result registers.
  `HPC_ASSERT_LATER(a_result_latency, s_tvalid && s_tready, m_tvalid)

  // A stalled result stays valid and unchanged.
  `HPC_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind height_profile_checker hpc_checker u_hpc_checker (.*);

// ===== sim/tb_height_profile_checker.sv =====
// Self-checking testbench for the height profile checker: directed and random profiles.
`timescale 1ns / 1ps
module tb_height_profile_checker;
  import hpc_pkg::*;

  localparam int StallLimit = 1000;
  localparam int NumSets    = 8;

  typedef struct packed {
    logic [HeightW-1:0] height;
    logic               metal;
    logic               start;
    logic               known;
    phase_t             want;
  } probe_t;

  typedef struct packed {
    logic   part_ok;
    phase_t phase;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [IdxW-1:0]     cfg_index = '0;
  logic [CfgW-1:0]     cfg_wr_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [1:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;

  cfg_t     live_cfg;
  phase_t   track_phase;
  verdict_t pending_verdicts[$];
  bit       idle_on;
  bit       hold_req;
  int       items_sent;
  int       results_seen;
  int       parts_accepted;
  int       parts_rejected;
  int       mismatches;
  int       cfg_sets;

  probe_t probes [0:26] = '{
    '{12'd4095, 1'b1, 1'b1, 1'b1, PH_IDLE},
    '{12'd3400, 1'b0, 1'b0, 1'b1, PH_A1},
    '{12'd3400, 1'b1, 1'b0, 1'b0, PH_IDLE},
    '{12'd3700, 1'b0, 1'b0, 1'b1, PH_B},
    '{12'd3400, 1'b0, 1'b1, 1'b1, PH_A2},
    '{12'd3050, 1'b0, 1'b0, 1'b1, PH_C},
    '{12'd3769, 1'b0, 1'b0, 1'b1, PH_ACCEPT},
    '{12'd3769, 1'b0, 1'b1, 1'b0, PH_IDLE},
    '{12'd0,    1'b1, 1'b0, 1'b1, PH_ACCEPT},
    '{12'd3749, 1'b1, 1'b0, 1'b1, PH_IDLE},
    '{12'd0,    1'b0, 1'b0, 1'b1, PH_REJECT},
    '{12'd4095, 1'b1, 1'b0, 1'b1, PH_REJECT},
    '{12'd0,    1'b0, 1'b1, 1'b1, PH_IDLE},
    '{12'd3338, 1'b0, 1'b0, 1'b1, PH_A1},
    '{12'd3477, 1'b0, 1'b0, 1'b1, PH_A1},
    '{12'd3478, 1'b0, 1'b0, 1'b1, PH_REJECT},
    '{12'd4095, 1'b1, 1'b1, 1'b1, PH_IDLE},
    '{12'd3337, 1'b0, 1'b0, 1'b1, PH_REJECT},
    '{12'd4095, 1'b0, 1'b1, 1'b1, PH_IDLE},
    '{12'd3400, 1'b0, 1'b0, 1'b0, PH_IDLE},
    '{12'd3669, 1'b0, 1'b0, 1'b1, PH_B},
    '{12'd3747, 1'b0, 1'b0, 1'b0, PH_IDLE},
    '{12'd3338, 1'b0, 1'b0, 1'b1, PH_A2},
    '{12'd3132, 1'b0, 1'b0, 1'b1, PH_C},
    '{12'd3013, 1'b0, 1'b0, 1'b1, PH_C},
    '{12'd3012, 1'b0, 1'b0, 1'b1, PH_REJECT},
    '{12'd2048, 1'b0, 1'b1, 1'b1, PH_IDLE}
  };

  height_profile_checker dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic phase_t profile_step(input phase_t cur, input cfg_t c,
                                          input logic [HeightW-1:0] h, input logic metal,
                                          input logic start);
    int  t;
    int  hv;
    bit  in_a;
    bit  in_b;
    bit  in_c;
    bit  on_belt;
    t       = int'(c.tolerance);
    hv      = int'(h);
    in_a    = hv >= int'(c.win_a_low) - t && hv <= int'(c.win_a_high) + t;
    in_b    = hv >= int'(c.win_b_low) - t && hv <= int'(c.win_b_high) + t;
    in_c    = hv >= int'(c.win_c_low) - t && hv <= int'(c.win_c_high) + t;
    on_belt = hv >= int'(c.belt_level) - t;
    case (cur)
      PH_A1:     return in_a ? PH_A1 : (in_b ? PH_B : PH_REJECT);
      PH_B:      return in_b ? PH_B : (in_a ? PH_A2 : PH_REJECT);
      PH_A2:     return in_a ? PH_A2 : (in_c ? PH_C : PH_REJECT);
      PH_C:      return in_c ? PH_C : (on_belt ? PH_ACCEPT : PH_REJECT);
      PH_ACCEPT: return (on_belt && metal) ? PH_IDLE : PH_ACCEPT;
      PH_REJECT: return start ? PH_IDLE : PH_REJECT;
      default:   return on_belt ? PH_IDLE : (in_a ? PH_A1 : PH_REJECT);
    endcase
  endfunction

  // Random height that passes the window test of [lo, hi] under the current tolerance, or any height if none can.
  function automatic logic [HeightW-1:0] height_near(input int lo, input int hi);
    int a;
    int b;
    a = lo - int'(live_cfg.tolerance);
    b = hi + int'(live_cfg.tolerance);
    if (a < 0) a = 0;
    if (b > 4095) b = 4095;
    if (a > b) return HeightW'($urandom_range(0, 4095));
    return HeightW'($urandom_range(b, a));
  endfunction

  // Belt above B above A above C, spaced so that no sample passes two tests.
  function automatic cfg_t random_layout(input int tol, input int wmax);
    cfg_t c;
    int   top;
    int   gap;
    int   w;
    gap          = 2 * tol + 1 + $urandom_range(0, 20);
    top          = $urandom_range(3300, 4095);
    c.tolerance  = TolW'(tol);
    c.belt_level = HeightW'(top);
    w            = $urandom_range(0, wmax);
    c.win_b_high = HeightW'(top - gap);
    c.win_b_low  = HeightW'(top - gap - w);
    top          = top - gap - w;
    w            = $urandom_range(0, wmax);
    c.win_a_high = HeightW'(top - gap);
    c.win_a_low  = HeightW'(top - gap - w);
    top          = top - gap - w;
    w            = $urandom_range(0, wmax);
    c.win_c_high = HeightW'(top - gap);
    c.win_c_low  = HeightW'(top - gap - w);
    return c;
  endfunction

  function automatic void flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at result %0d: expected %0d, got %0d",
               what, results_seen, want, got);
  endfunction

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    logic [3:0] junk;
    junk = 4'($urandom_range(0, 15));
    write_reg(REG_TOLERANCE, {junk, c.tolerance});
    write_reg(REG_BELT_LEVEL, c.belt_level);
    write_reg(REG_WIN_A_HIGH, c.win_a_high);
    write_reg(REG_WIN_A_LOW, c.win_a_low);
    write_reg(REG_WIN_B_HIGH, c.win_b_high);
    write_reg(REG_WIN_B_LOW, c.win_b_low);
    write_reg(REG_WIN_C_HIGH, c.win_c_high);
    write_reg(REG_WIN_C_LOW, c.win_c_low);
    cfg_wr_en <= 1'b0;
    live_cfg = c;
    cfg_sets++;
  endtask

  task automatic send_item(input logic [HeightW-1:0] h, input logic metal, input logic start,
                           input logic known, input phase_t want);
    phase_t nxt;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, h};
    s_tuser  <= {start, metal};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    nxt = known ? want : profile_step(track_phase, live_cfg, h, metal, start);
    if (nxt == PH_ACCEPT && track_phase != PH_ACCEPT) parts_accepted++;
    if (nxt == PH_REJECT && track_phase != PH_REJECT) parts_rejected++;
    track_phase = nxt;
    pending_verdicts.push_back('{part_ok: (nxt != PH_REJECT), phase: nxt});
    items_sent++;
  endtask

  task automatic send_noise();
    send_item(HeightW'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'b0, PH_IDLE);
  endtask

  // One workpiece passing the sensor; a broken one has a single sample replaced by noise.
  task automatic run_profile(input bit broken);
    probe_t seq[$];
    probe_t p;
    int     n;
    int     k;
    n = 0;
    while (track_phase != PH_IDLE && n < 4) begin
      send_item(height_near(live_cfg.belt_level, 4095), 1'b1, 1'b1, 1'b0, PH_IDLE);
      n++;
    end
    p = '0;
    repeat ($urandom_range(1, 2)) begin
      p.height = height_near(live_cfg.belt_level, 4095);
      p.metal  = 1'($urandom_range(0, 1));
      seq.push_back(p);
    end
    for (int seg = 0; seg < 4; seg++) begin
      repeat ($urandom_range(1, 3)) begin
        case (seg)
          0, 2:    p.height = height_near(live_cfg.win_a_low, live_cfg.win_a_high);
          1:       p.height = height_near(live_cfg.win_b_low, live_cfg.win_b_high);
          default: p.height = height_near(live_cfg.win_c_low, live_cfg.win_c_high);
        endcase
        p.metal = 1'($urandom_range(0, 1));
        seq.push_back(p);
      end
    end
    repeat ($urandom_range(0, 2)) begin
      p.height = height_near(live_cfg.belt_level, 4095);
      p.metal  = 1'b0;
      seq.push_back(p);
    end
    p.height = height_near(live_cfg.belt_level, 4095);
    p.metal  = 1'b1;
    seq.push_back(p);
    if (broken) begin
      k = $urandom_range(0, seq.size() - 1);
      seq[k].height = HeightW'($urandom_range(0, 4095));
    end
    foreach (seq[i])
      send_item(seq[i].height, seq[i].metal, 1'($urandom_range(0, 1)), 1'b0, PH_IDLE);
  endtask

  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : receiver
    verdict_t want;
    int       burst;
    int       long_hold;
    burst     = 0;
    long_hold = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          flag_mismatch("result with nothing pending", -1, int'(m_tdata[2:0]));
        end else begin
          want = pending_verdicts.pop_front();
          if (m_tdata[2:0] !== want.phase)
            flag_mismatch("phase_code", int'(want.phase), int'(m_tdata[2:0]));
          if (m_tuser !== want.part_ok)
            flag_mismatch("part_ok", int'(want.part_ok), int'(m_tuser));
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        long_hold = 60;
        m_tready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("item flow stalled for %0d cycles", StallLimit);
    $display("FAIL height_profile_checker");
    $finish;
  end

  initial begin : stimulus
    cfg_t c;
    int   target;
    int   span;
    bit   pressed;
    live_cfg = '{tolerance: RST_TOLERANCE, belt_level: RST_BELT_LEVEL,
                 win_a_high: RST_WIN_A_HIGH, win_a_low: RST_WIN_A_LOW,
                 win_b_high: RST_WIN_B_HIGH, win_b_low: RST_WIN_B_LOW,
                 win_c_high: RST_WIN_C_HIGH, win_c_low: RST_WIN_C_LOW};
    track_phase = PH_IDLE;
    idle_on     = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i])
      send_item(probes[i].height, probes[i].metal, probes[i].start,
                probes[i].known, probes[i].want);
    settle_block();

    for (int set = 0; set < NumSets; set++) begin
      span = 220;
      case (set)
        0: c = random_layout(0, 120);
        1: begin
          c = '{tolerance: 8'd255, belt_level: 12'd4095,
                win_a_high: 12'd2000, win_a_low: 12'd1800,
                win_b_high: 12'd4095, win_b_low: 12'd3400,
                win_c_high: 12'd0, win_c_low: 12'd0};
          span = 150;
        end
        3: begin
          c = '{tolerance: 8'd0, belt_level: 12'd0,
                win_a_high: 12'd4095, win_a_low: 12'd4095,
                win_b_high: 12'd0, win_b_low: 12'd0,
                win_c_high: 12'd4095, win_c_low: 12'd4095};
          span = 60;
        end
        4: begin
          // Low bound above high bound: only the tolerance margins can match.
          c = random_layout(40, 60);
          {c.win_a_low, c.win_a_high} = {c.win_a_high, c.win_a_low};
          {c.win_b_low, c.win_b_high} = {c.win_b_high, c.win_b_low};
          {c.win_c_low, c.win_c_high} = {c.win_c_high, c.win_c_low};
        end
        NumSets - 1: c = '{tolerance: RST_TOLERANCE, belt_level: RST_BELT_LEVEL,
                           win_a_high: RST_WIN_A_HIGH, win_a_low: RST_WIN_A_LOW,
                           win_b_high: RST_WIN_B_HIGH, win_b_low: RST_WIN_B_LOW,
                           win_c_high: RST_WIN_C_HIGH, win_c_low: RST_WIN_C_LOW};
        default: c = random_layout($urandom_range(1, 60), 120);
      endcase
      load_config(c);
      idle_on = (set == NumSets - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      pressed = !(set == 2 || set == 5);
      target  = items_sent + span;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 7) run_profile($urandom_range(0, 4) == 0);
        else repeat ($urandom_range(1, 4)) send_noise();
        if (!pressed && items_sent >= target - span / 2) begin
          hold_req = 1'b1;
          pressed  = 1'b1;
        end
      end
      settle_block();
    end

    $display("Covered %0d items over %0d register settings plus the reset values.",
             items_sent, cfg_sets);
    $display("Parts accepted: %0d, rejections: %0d, results checked: %0d.",
             parts_accepted, parts_rejected, results_seen);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("PASS height_profile_checker");
    end else begin
      $display("%0d mismatches, %0d results still pending", mismatches,
               pending_verdicts.size());
      $display("FAIL height_profile_checker");
    end
    $finish;
  end

endmodule
